@@ rtl/fir16s_pkg.sv @@
// Shared constants, command codes and word types for the saturating FIR filter.
package fir16s_pkg;

    localparam int TAPS      = 16;
    localparam int SMP_W     = 16;
    localparam int COEF_W    = 16;
    localparam int TAP_IDX_W = 4;
    localparam int PROD_W    = SMP_W + COEF_W;
    localparam int OUT_W     = 32;
    localparam int ACC_W     = PROD_W + $clog2(TAPS);
    localparam int DONE_CNT  = TAPS + 1;
    localparam int CNT_W     = $clog2(DONE_CNT + 1);

    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_COEFF  = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]                  command;
        logic signed [SMP_W-1:0]     sample;
        logic [TAP_IDX_W-1:0]        tap_index;
        logic signed [COEF_W-1:0]    tap_value;
    } cmd_t;

    typedef struct packed {
        logic signed [OUT_W-1:0]     filtered;
        logic                        clipped;
    } res_t;

    // Broadcast to every cell of the tap chain
    typedef struct packed {
        logic                        shift;
        logic                        clear;
        logic signed [COEF_W-1:0]    coef_value;
    } cell_ctrl_t;

endpackage

@@ rtl/fir16s_cell.sv @@
// One tap cell: holds a history sample and a coefficient, adds its product to the passing sum.
module fir16s_cell
    import fir16s_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cell_ctrl_t               ctrl,
    input  logic                     coef_we,
    input  logic signed [SMP_W-1:0]  sample_in,
    output logic signed [SMP_W-1:0]  sample_out,
    input  logic signed [ACC_W-1:0]  psum_in,
    output logic signed [ACC_W-1:0]  psum_out
);

    logic signed [SMP_W-1:0]  hist_reg;
    logic signed [SMP_W-1:0]  hist_next;
    logic signed [COEF_W-1:0] coef_reg;
    logic signed [COEF_W-1:0] coef_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  psum_reg;
    logic signed [ACC_W-1:0]  psum_next;

    always_comb
    begin
        hist_next = hist_reg;
        if (ctrl.clear)
        begin
            hist_next = '0;
        end
        else if (ctrl.shift)
        begin
            hist_next = sample_in;
        end
    end

    assign coef_next = coef_we ? ctrl.coef_value : coef_reg;
    // Widen both operands so the product keeps its full width
    assign prod_next = PROD_W'(coef_reg) * PROD_W'(hist_reg);
    assign psum_next = psum_in + ACC_W'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg <= '0;
            coef_reg <= '0;
        end
        else
        begin
            hist_reg <= hist_next;
            coef_reg <= coef_next;
        end
    end

    // Product and partial sum run freely every cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        psum_reg <= psum_next;
    end

    assign sample_out = hist_reg;
    assign psum_out   = psum_reg;

endmodule

@@ rtl/fir_filter_16tap_saturating.sv @@
// Top level: command decode, tap cell chain, saturation and result register.
// A sample word is taken, then its partial sum ripples one cell per cycle down the chain.
// Command words are stalled while a filter pass is busy; the pass ends when the final sum
// is loaded into the result register, which waits while a held result is stalled;
// coefficient and clear words do not start a pass.
// Reset clears history and coefficients to zero and empties the result register.
module fir_filter_16tap_saturating
    import fir16s_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_stall,
    output res_t res
);

    logic                    busy_reg;
    logic                    busy_next;
    logic [CNT_W-1:0]        cnt_reg;
    logic [CNT_W-1:0]        cnt_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    res_t                    res_reg;
    res_t                    res_next;

    logic                    cmd_take;
    logic                    finish;
    cell_ctrl_t              ctrl;
    logic [TAPS-1:0]         coef_we;
    logic signed [SMP_W-1:0] smp_chain [TAPS+1];
    logic signed [ACC_W-1:0] sum_chain [TAPS+1];
    logic signed [ACC_W-1:0] sum_last;
    logic [ACC_W-OUT_W:0]    top_bits;
    logic                    ovf;

    assign cmd_stall = busy_reg;
    assign cmd_take  = cmd_valid && !busy_reg;

    assign ctrl.shift      = cmd_take && (cmd.command == CMD_SAMPLE);
    assign ctrl.clear      = cmd_take && (cmd.command == CMD_CLEAR);
    assign ctrl.coef_value = cmd.tap_value;

    assign smp_chain[0] = cmd.sample;
    assign sum_chain[0] = '0;

    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        assign coef_we[k] = cmd_take && (cmd.command == CMD_COEFF)
                            && (32'(cmd.tap_index) == k);

        fir16s_cell u_cell
        (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .coef_we    (coef_we[k]),
            .sample_in  (smp_chain[k]),
            .sample_out (smp_chain[k+1]),
            .psum_in    (sum_chain[k]),
            .psum_out   (sum_chain[k+1])
        );
    end

    assign sum_last = sum_chain[TAPS];

    // Out of range when the bits above the 32-bit sign are not all copies of it
    assign top_bits = sum_last[ACC_W-1:OUT_W-1];
    assign ovf      = !((&top_bits) || !(|top_bits));

    assign finish = busy_reg && (cnt_reg == CNT_W'(DONE_CNT))
                    && (!res_valid_reg || !res_stall);

    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (ctrl.shift)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (finish)
        begin
            busy_next      = 1'b0;
            res_valid_next = 1'b1;
            res_next.clipped = ovf;
            if (ovf)
            begin
                res_next.filtered = sum_last[ACC_W-1]
                                    ? {1'b1, {(OUT_W-1){1'b0}}}
                                    : {1'b0, {(OUT_W-1){1'b1}}};
            end
            else
            begin
                res_next.filtered = sum_last[OUT_W-1:0];
            end
        end
        else if (busy_reg && (cnt_reg != CNT_W'(DONE_CNT)))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    a_sample_starts_work : assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.shift |=> (busy_reg && cnt_reg == '0))
        else $error("sample word did not start a filter pass");

    a_result_from_finish : assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !$past(res_valid_reg)) |-> $past(finish))
        else $error("result appeared without a finished pass");

    a_sum_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg == CNT_W'(DONE_CNT) && !finish) |=> $stable(sum_last))
        else $error("final sum moved while waiting for the result register");

    a_no_take_busy : assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (coef_we == '0 && !ctrl.clear))
        else $error("store changed during a filter pass");

endmodule

@@ verif/fir_filter_16tap_saturating_tb.sv @@
// Self-checking testbench for the 16-tap saturating FIR filter: directed table, then random words.
`timescale 1ns / 1ps

module fir_filter_16tap_saturating_tb;
    import fir16s_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         LIMIT_CYCLES   = 200000;
    localparam int         HOLD_CYCLES    = 400;
    localparam int         DRAIN_CYCLES   = 40;
    localparam int         RAND_PER_PHASE = 96;
    localparam longint     SUM_MAX        = 64'sd2147483647;
    localparam longint     SUM_MIN        = -64'sd2147483648;

    typedef struct {
        cmd_t word;
        bit   typed;
        res_t out;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic cmd_valid;
    logic cmd_stall;
    cmd_t cmd;
    logic res_valid;
    logic res_stall;
    res_t res;

    // Shadow filter state
    logic signed [SMP_W-1:0]  smp_hist [TAPS];
    logic signed [COEF_W-1:0] tap_coef [TAPS];

    res_t     pending_res [$];
    dir_row_t dir_rows [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int err_cnt        = 0;
    int cycle_cnt      = 0;
    bit hold_go        = 1'b0;
    bit hold_active;

    fir_filter_16tap_saturating uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Advance the shadow filter by one word; return 1 when the word yields a sum
    function automatic bit fir_eval(input cmd_t w, output res_t y);
        longint acc;
        int     i;
        fir_eval = 1'b0;
        y        = '0;
        case (w.command)
            CMD_SAMPLE:
            begin
                for (i = TAPS - 1; i > 0; i--)
                    smp_hist[i] = smp_hist[i-1];
                smp_hist[0] = w.sample;
                acc = 0;
                for (i = 0; i < TAPS; i++)
                    acc += longint'(tap_coef[i]) * longint'(smp_hist[i]);
                if (acc > SUM_MAX)
                begin
                    y.filtered = 32'h7FFF_FFFF;
                    y.clipped  = 1'b1;
                end
                else if (acc < SUM_MIN)
                begin
                    y.filtered = 32'h8000_0000;
                    y.clipped  = 1'b1;
                end
                else
                begin
                    y.filtered = acc[31:0];
                    y.clipped  = 1'b0;
                end
                fir_eval = 1'b1;
            end
            CMD_COEFF:
                if (w.tap_index < TAPS)
                    tap_coef[w.tap_index] = w.tap_value;
            CMD_CLEAR:
                for (i = 0; i < TAPS; i++)
                    smp_hist[i] = '0;
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] rand16();
        logic [31:0] u;
        u = $urandom;
        case ($urandom_range(9))
            0:       rand16 = 16'sh8000;
            1:       rand16 = 16'sh7FFF;
            default: rand16 = u[15:0];
        endcase
    endfunction

    function automatic cmd_t mk_word(input logic [1:0] c, input logic signed [15:0] s,
                                     input logic [3:0] k, input logic signed [15:0] v);
        cmd_t w;
        w.command   = c;
        w.sample    = s;
        w.tap_index = k;
        w.tap_value = v;
        return w;
    endfunction

    function automatic res_t res_of(input logic signed [31:0] f, input logic c);
        res_t r;
        r.filtered = f;
        r.clipped  = c;
        return r;
    endfunction

    function automatic cmd_t rand_word();
        cmd_t        w;
        int          pick;
        logic [31:0] u;
        u           = $urandom;
        pick        = $urandom_range(99);
        w.sample    = rand16();
        w.tap_value = rand16();
        w.tap_index = u[3:0];
        if (pick < 55)
            w.command = CMD_SAMPLE;
        else if (pick < 85)
            w.command = CMD_COEFF;
        else if (pick < 93)
            w.command = CMD_CLEAR;
        else
            w.command = CMD_UNUSED;
        return w;
    endfunction

    task automatic add_row(input cmd_t w, input bit typed, input res_t out);
        dir_row_t r;
        r.word  = w;
        r.typed = typed;
        r.out   = out;
        dir_rows.push_back(r);
    endtask

    task automatic log_err(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("mismatch: %s", msg);
    endtask

    // Offer one word, hold it until taken, then queue its expected sum if it yields one
    task automatic push_word(input cmd_t w, input bit typed, input res_t typed_out);
        res_t y;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd       <= w;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (cmd_stall);
        if (fir_eval(w, y))
            pending_res.push_back(typed ? typed_out : y);
    endtask

    // Long receiver hold-off, counted here
    initial
    begin
        hold_active = 1'b0;
        wait (hold_go);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_active)
                res_stall <= 1'b1;
            else
                res_stall <= (sink_stall_pct != 0 && $urandom_range(99) < sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_res
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_res.size() == 0)
                log_err($sformatf("unexpected word filtered=%0d clipped=%0b",
                                  res.filtered, res.clipped));
            else
            begin
                want = pending_res.pop_front();
                if (res.filtered !== want.filtered)
                    log_err($sformatf("filtered exp %0d got %0d", want.filtered, res.filtered));
                if (res.clipped !== want.clipped)
                    log_err($sformatf("clipped exp %0b got %0b", want.clipped, res.clipped));
            end
        end
    end

    initial
    begin
        int i;
        int ph;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        for (i = 0; i < TAPS; i++)
        begin
            smp_hist[i] = '0;
            tap_coef[i] = '0;
        end

        // Taps all zero after reset
        add_row(mk_word(CMD_SAMPLE, 16'sd100, 4'd0, 16'sd0), 1'b1, res_of(32'sd0, 1'b0));
        add_row(mk_word(CMD_UNUSED, 16'sh8000, 4'hF, 16'sh7FFF), 1'b0, '0);
        add_row(mk_word(CMD_COEFF, 16'sd0, 4'd0, 16'sh8000), 1'b0, '0);
        add_row(mk_word(CMD_COEFF, 16'sd0, 4'd1, 16'sh8000), 1'b0, '0);
        add_row(mk_word(CMD_COEFF, 16'sd0, 4'd2, 16'sh8000), 1'b0, '0);
        add_row(mk_word(CMD_CLEAR, 16'sh7FFF, 4'd9, 16'sh1234), 1'b0, '0);
        add_row(mk_word(CMD_SAMPLE, 16'sh8000, 4'd0, 16'sd0), 1'b1,
                res_of(32'sd1073741824, 1'b0));
        // Two full-scale products overflow the positive range
        add_row(mk_word(CMD_SAMPLE, 16'sh8000, 4'd0, 16'sd0), 1'b1,
                res_of(32'h7FFF_FFFF, 1'b1));
        add_row(mk_word(CMD_SAMPLE, 16'sh7FFF, 4'd0, 16'sd0), 1'b0, '0);
        add_row(mk_word(CMD_SAMPLE, 16'sh7FFF, 4'd0, 16'sd0), 1'b0, '0);
        // Three large negative products underflow
        add_row(mk_word(CMD_SAMPLE, 16'sh7FFF, 4'd0, 16'sd0), 1'b1,
                res_of(32'h8000_0000, 1'b1));
        add_row(mk_word(CMD_COEFF, 16'sd0, 4'd15, 16'sh7FFF), 1'b0, '0);
        add_row(mk_word(CMD_COEFF, 16'sd0, 4'd0, 16'sd0), 1'b0, '0);
        add_row(mk_word(CMD_SAMPLE, 16'sd0, 4'd0, 16'sd0), 1'b0, '0);
        add_row(mk_word(CMD_CLEAR, 16'sh5A5A, 4'd6, 16'shA5A5), 1'b0, '0);
        add_row(mk_word(CMD_SAMPLE, -16'sd1, 4'd0, 16'sd0), 1'b0, '0);
        add_row(mk_word(CMD_COEFF, 16'sd0, 4'd7, 16'sd1), 1'b0, '0);
        add_row(mk_word(CMD_SAMPLE, 16'sh7FFF, 4'd0, 16'sd0), 1'b0, '0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            push_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].out);

        for (ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 56;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 56;
                end
                3:
                begin
                    src_idle_pct   = 29;
                    sink_stall_pct = 29;
                end
                default:
                begin
                    // Keep offering while the output is held off
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                    hold_go        = 1'b1;
                end
            endcase
            for (i = 0; i < RAND_PER_PHASE; i++)
                push_word(rand_word(), 1'b0, '0);
        end
        cmd_valid <= 1'b0;

        while (pending_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ fir_filter_16tap_saturating.f @@
rtl/fir16s_pkg.sv
rtl/fir16s_cell.sv
rtl/fir_filter_16tap_saturating.sv
verif/fir_filter_16tap_saturating_tb.sv
